FILE: design/bti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bti_pkg;

    // Fixed field widths of the breakpoint table.
    localparam int FREQ_W     = 24;
    localparam int ATTEN_W    = 16;
    localparam int ENTRY_W    = FREQ_W + ATTEN_W;
    localparam int PROD_W     = FREQ_W + ATTEN_W;
    localparam int COUNT_W    = 6;
    localparam int INDEX_W    = 5;

    // Register file of the configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_POINT_COUNT = 1'b0;

    // The quotient of an interpolation step never exceeds the attenuation span.
    localparam int DIV_STEPS  = ATTEN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_INTERP = 2'd0,
        REG_EXACT  = 2'd1,
        REG_BELOW  = 2'd2,
        REG_ABOVE  = 2'd3
    } region_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [FREQ_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [ATTEN_W-1:0]   quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/bti_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bti_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/bti_div.sv
`timescale 1ns / 1ps
`default_nettype none

module bti_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bti_pkg::div_req_t req,
    output bti_pkg::div_rsp_t      rsp
);

    import bti_pkg::*;

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the quotient fits in DIV_STEPS bits, so the upper dividend bits
    // already form a partial remainder below the divisor.
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FREQ_W-1:0]     rem_reg, rem_next;
    logic [DIV_STEPS-1:0]  low_reg, low_next;
    logic [FREQ_W-1:0]     den_reg, den_next;
    logic [FREQ_W:0]       trial;
    logic [FREQ_W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        trial     = {rem_reg, low_reg[DIV_STEPS-1]};
        diff      = trial - {1'b0, den_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            rem_next  = req.dividend[PROD_W-1:DIV_STEPS];
            low_next  = req.dividend[DIV_STEPS-1:0];
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[FREQ_W])
            begin
                rem_next = diff[FREQ_W-1:0];
                low_next = {low_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FREQ_W-1:0];
                low_next = {low_reg[DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = low_reg;

endmodule

`default_nettype wire

FILE: design/breakpoint_table_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Beat contents
// in        receive    in_valid/in_stall   operation, point_index, point_freq,
//                                          point_atten, query_freq
// out       send       out_valid/out_stall atten_out, region
// apb       slave      psel/penable/pready point_count at byte address 0
//
// Between one accepted beat and the next: a write goes straight to ST_DONE, which moves its zero
// result into the output register. A query reads the last breakpoint in ST_LAST and stops when
// clamped above; else ST_SCAN makes one memory read per breakpoint up to index k, ending at a
// clamp below or an exact hit or interpolating with a multiply and a 16-step divider.
// Reset clears the control state and sets point_count to 1; the table is undefined until
// written. The input stalls while an item is in flight and while its result waits for the
// output register to empty.

module breakpoint_table_interpolator #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bti_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire logic [bti_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic      [bti_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                      pready,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 operation,
    input  wire logic [bti_pkg::INDEX_W-1:0]          point_index,
    input  wire logic signed [bti_pkg::FREQ_W-1:0]    point_freq,
    input  wire logic [bti_pkg::ATTEN_W-1:0]          point_atten,
    input  wire logic signed [bti_pkg::FREQ_W-1:0]    query_freq,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic      [bti_pkg::ATTEN_W-1:0]          atten_out,
    output logic      [1:0]                           region
);

    import bti_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    // Wide enough for both the count register and MAX_POINTS itself.
    localparam int CW    = ($clog2(MAX_POINTS + 1) > COUNT_W) ?
                           $clog2(MAX_POINTS + 1) : COUNT_W;

    // Configuration register.
    logic [COUNT_W-1:0] point_count_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_POINT_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_POINT_COUNT)
        begin
            prdata = CFG_DATA_W'(point_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            point_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Effective count: zero counts as one, and the count saturates at the
    // table depth.
    logic [CW-1:0]    count_w;
    logic [CW-1:0]    count_eff;
    logic [CW-1:0]    count_m1;
    logic [IDX_W-1:0] last_idx;

    always_comb
    begin
        count_w = CW'(point_count_reg);
        if (count_w == '0)
        begin
            count_eff = CW'(1);
        end
        else if (count_w > CW'(MAX_POINTS))
        begin
            count_eff = CW'(MAX_POINTS);
        end
        else
        begin
            count_eff = count_w;
        end
        count_m1 = count_eff - CW'(1);
        last_idx = count_m1[IDX_W-1:0];
    end

    // Table memory: frequency in the upper bits, attenuation in the lower.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [CW-1:0]      widx;

    assign widx      = CW'(point_index);
    assign ram_waddr = widx[IDX_W-1:0];
    assign ram_wdata = {point_freq, point_atten};

    bti_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic signed [FREQ_W-1:0] rd_freq;
    logic        [ATTEN_W-1:0] rd_atten;

    assign rd_freq  = $signed(ram_rdata[ENTRY_W-1:ATTEN_W]);
    assign rd_atten = ram_rdata[ATTEN_W-1:0];

    // Divider for the interpolation step.
    div_req_t div_req;
    div_rsp_t div_rsp;

    bti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer state.
    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [FREQ_W-1:0] q_reg, q_next;
    logic signed [FREQ_W-1:0] f0_reg, f0_next;
    logic signed [FREQ_W-1:0] f1_reg, f1_next;
    logic [ATTEN_W-1:0]       a0_reg, a0_next;
    logic [ATTEN_W-1:0]       a1_reg, a1_next;
    logic [FREQ_W-1:0]        num_reg, num_next;
    logic [FREQ_W-1:0]        den_reg, den_next;
    logic [ATTEN_W-1:0]       mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [ATTEN_W-1:0]       res_atten_reg, res_atten_next;
    region_t                  res_region_reg, res_region_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ATTEN_W-1:0]       out_atten_reg, out_atten_next;
    region_t                  out_region_reg, out_region_next;

    logic                     in_accept;
    logic                     out_free;
    logic signed [FREQ_W:0]   num_w;
    logic signed [FREQ_W:0]   den_w;
    logic signed [ATTEN_W:0]  da_w;
    logic [ATTEN_W:0]         da_mag;
    logic [ATTEN_W:0]         sum_w;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        q_next          = q_reg;
        f0_next         = f0_reg;
        f1_next         = f1_reg;
        a0_next         = a0_reg;
        a1_next         = a1_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        res_atten_next  = res_atten_reg;
        res_region_next = res_region_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_atten_next  = out_atten_reg;
        out_region_next = out_region_reg;
        ram_we          = 1'b0;
        ram_raddr       = idx_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = den_reg;

        num_w  = {q_reg[FREQ_W-1], q_reg} - {f0_reg[FREQ_W-1], f0_reg};
        den_w  = {f1_reg[FREQ_W-1], f1_reg} - {f0_reg[FREQ_W-1], f0_reg};
        da_w   = $signed({1'b0, a1_reg}) - $signed({1'b0, a0_reg});
        da_mag = da_w[ATTEN_W] ? -da_w : da_w;
        sum_w  = neg_reg ? ({1'b0, a0_reg} - {1'b0, div_rsp.quotient})
                         : ({1'b0, a0_reg} + {1'b0, div_rsp.quotient});

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = last_idx;
                if (in_accept)
                begin
                    q_next          = query_freq;
                    res_atten_next  = '0;
                    res_region_next = REG_INTERP;
                    if (operation == OP_WRITE)
                    begin
                        // Writes beyond the table depth are dropped.
                        ram_we     = (widx < CW'(MAX_POINTS));
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LAST;
                    end
                end
            end

            ST_LAST:
            begin
                ram_raddr = '0;
                idx_next  = '0;
                if (q_reg > rd_freq)
                begin
                    res_atten_next  = rd_atten;
                    res_region_next = REG_ABOVE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                ram_raddr = idx_reg + IDX_W'(1);
                if ((idx_reg == '0) && (q_reg < rd_freq))
                begin
                    res_atten_next  = rd_atten;
                    res_region_next = REG_BELOW;
                    state_next      = ST_DONE;
                end
                else if (rd_freq == q_reg)
                begin
                    res_atten_next  = rd_atten;
                    res_region_next = REG_EXACT;
                    state_next      = ST_DONE;
                end
                else if (rd_freq > q_reg)
                begin
                    f1_next    = rd_freq;
                    a1_next    = rd_atten;
                    state_next = ST_PREP;
                end
                else
                begin
                    f0_next  = rd_freq;
                    a0_next  = rd_atten;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_PREP:
            begin
                // Both differences are positive here; the sign of the
                // attenuation slope is kept apart so the quotient truncates
                // toward zero.
                num_next   = num_w[FREQ_W-1:0];
                den_next   = den_w[FREQ_W-1:0];
                neg_next   = da_w[ATTEN_W];
                mag_next   = da_mag[ATTEN_W-1:0];
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = {{ATTEN_W{1'b0}}, num_reg} * {{FREQ_W{1'b0}}, mag_reg};
                state_next = ST_START;
            end

            ST_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_atten_next  = sum_w[ATTEN_W-1:0];
                    res_region_next = REG_INTERP;
                    state_next      = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_atten_next  = res_atten_reg;
                    out_region_next = res_region_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        q_reg          <= q_next;
        f0_reg         <= f0_next;
        f1_reg         <= f1_next;
        a0_reg         <= a0_next;
        a1_reg         <= a1_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        res_atten_reg  <= res_atten_next;
        res_region_reg <= res_region_next;
        out_atten_reg  <= out_atten_next;
        out_region_reg <= out_region_next;
    end

    assign out_valid = out_valid_reg;
    assign atten_out = out_atten_reg;
    assign region    = out_region_reg;

endmodule

`default_nettype wire

FILE: design/bti_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bti_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [bti_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bti_pkg::CFG_DATA_W-1:0] pwdata,
    input  wire logic [bti_pkg::CFG_DATA_W-1:0] prdata,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic                           operation,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [bti_pkg::ATTEN_W-1:0]    atten_out,
    input  wire logic [1:0]                     region
);

    import bti_pkg::*;

    // Only one item is in flight: an accepted beat stalls the input next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted a second beat while an item was in flight");

    // A write with an empty output register shows its zero result once ST_DONE has loaded it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == OP_WRITE) && !out_valid)
        |-> ##2 (out_valid && (atten_out == '0) && (region == REG_INTERP)))
    else $error("write beat did not produce its zero result in time");

    // A point_count write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[CFG_ADDR_W-1:2] == REG_POINT_COUNT))
        |=> ((paddr[CFG_ADDR_W-1:2] != REG_POINT_COUNT)
             || (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))))
    else $error("point_count read back differs from the value written");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(atten_out) && $stable(region)))
    else $error("stalled result beat changed");

endmodule

bind breakpoint_table_interpolator bti_checker u_bti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .atten_out (atten_out),
    .region    (region)
);

`default_nettype wire
